// File: hdl/llnp_pkg.sv
package llnp_pkg;

    localparam int NODE_COUNT = 256;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = $clog2(NODE_COUNT);
    localparam int STEP_W     = IDX_W + 1;
    localparam int HEAD_W     = 9;
    localparam int DATA_W     = 32;

    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [STEP_W-1:0]     t_step;

    typedef struct packed {
        logic nil;
        t_idx idx;
    } t_ptr;

    localparam t_ptr PTR_NIL = '{nil: 1'b1, idx: '0};

    typedef enum logic [1:0] {
        OP_INS_FRONT  = 2'd0,
        OP_INS_SORTED = 2'd1,
        OP_DEL_FRONT  = 2'd2,
        OP_CMP        = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_ALLOC,
        S_WALK,
        S_LINK,
        S_LINK_PREV,
        S_DELETE,
        S_CMP,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic en;
        t_idx addr;
        t_ptr data;
    } t_link_wr;

    typedef struct packed {
        logic   en;
        t_idx   addr;
        t_value data;
    } t_value_wr;

    typedef struct packed {
        t_idx a;
        t_idx b;
    } t_rd_addr;

    function automatic t_ptr head_to_ptr(input logic [HEAD_W-1:0] h);
        t_ptr p;
        p.nil = h[HEAD_W-1] || ({1'b0, h} >= (HEAD_W+1)'(NODE_COUNT));
        p.idx = h[IDX_W-1:0];
        return p;
    endfunction

    function automatic logic [HEAD_W-1:0] ptr_to_head(input t_ptr p);
        logic [HEAD_W-1:0] h;
        if (p.nil) begin
            h = '1;
        end else begin
            h = HEAD_W'(p.idx);
        end
        return h;
    endfunction

endpackage

// File: hdl/llnp_link_store.sv
module llnp_link_store (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  llnp_pkg::t_link_wr  i_wr,
    input  llnp_pkg::t_rd_addr  i_rd_addr,
    output llnp_pkg::t_ptr      o_rd_a,
    output llnp_pkg::t_ptr      o_rd_b
);

    llnp_pkg::t_ptr r_mem [llnp_pkg::NODE_COUNT];
    logic [llnp_pkg::NODE_COUNT-1:0] r_vld;

    llnp_pkg::t_ptr r_rd_a;
    llnp_pkg::t_ptr r_rd_b;
    logic           r_vld_a;
    logic           r_vld_b;
    llnp_pkg::t_idx r_addr_a;
    llnp_pkg::t_idx r_addr_b;

    // unwritten entry i links to node i - 1, node 0 ends the chain
    function automatic llnp_pkg::t_ptr reset_link(input llnp_pkg::t_idx a);
        llnp_pkg::t_ptr p;
        if (a == '0) begin
            p = llnp_pkg::PTR_NIL;
        end else begin
            p.nil = 1'b0;
            p.idx = a - 1'b1;
        end
        return p;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_a   <= r_mem[i_rd_addr.a];
        r_rd_b   <= r_mem[i_rd_addr.b];
        r_vld_a  <= r_vld[i_rd_addr.a];
        r_vld_b  <= r_vld[i_rd_addr.b];
        r_addr_a <= i_rd_addr.a;
        r_addr_b <= i_rd_addr.b;
    end

    assign o_rd_a = r_vld_a ? r_rd_a : reset_link(r_addr_a);
    assign o_rd_b = r_vld_b ? r_rd_b : reset_link(r_addr_b);

endmodule

// File: hdl/llnp_value_store.sv
module llnp_value_store (
    input  logic                i_clk,
    input  llnp_pkg::t_value_wr i_wr,
    input  llnp_pkg::t_rd_addr  i_rd_addr,
    output llnp_pkg::t_value    o_rd_a,
    output llnp_pkg::t_value    o_rd_b
);

    llnp_pkg::t_value r_mem [llnp_pkg::NODE_COUNT];
    llnp_pkg::t_value r_rd_a;
    llnp_pkg::t_value r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_a <= r_mem[i_rd_addr.a];
        r_rd_b <= r_mem[i_rd_addr.b];
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

// File: hdl/linked_list_node_pool_core.sv
// Pool of 256 list nodes (value plus next link) with a free list threaded through the
// unused nodes. One request is worked at a time. A sorted insert walks the list from
// its head, reading one node per cycle from the registered-read value and link
// memories, at most 256 nodes; when the new node goes behind an existing one, the link
// of that node is rewritten in a further state. An ordered compare walks both lists in
// step. A dropped insert, a delete on an empty list and a compare with an empty list go
// straight from dispatch to finish. A new request is taken in idle, which the core
// enters as the previous result is loaded into the output register; that result may
// still wait there while the next request is worked.
// Head indices outside 0..255 are treated as an empty list.
module linked_list_node_pool_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [1:0]                             i_operation,
    input  logic signed [llnp_pkg::HEAD_W-1:0]     i_list_head,
    input  logic signed [llnp_pkg::HEAD_W-1:0]     i_other_head,
    input  logic signed [llnp_pkg::DATA_W-1:0]     i_value,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [llnp_pkg::HEAD_W-1:0]     o_new_head,
    output logic signed [llnp_pkg::HEAD_W-1:0]     o_slot,
    output logic signed [llnp_pkg::HEAD_W-1:0]     o_free_head,
    output logic [1:0]                             o_status,
    output logic                                   o_equal
);

    llnp_pkg::t_state  r_state, n_state;
    llnp_pkg::t_op     r_op, n_op;
    llnp_pkg::t_ptr    r_head, n_head;
    llnp_pkg::t_ptr    r_other, n_other;
    llnp_pkg::t_value  r_val, n_val;
    llnp_pkg::t_ptr    r_cur, n_cur;
    llnp_pkg::t_ptr    r_oth, n_oth;
    llnp_pkg::t_ptr    r_prev, n_prev;
    llnp_pkg::t_step   r_steps, n_steps;
    llnp_pkg::t_ptr    r_slot, n_slot;
    llnp_pkg::t_ptr    r_newh, n_newh;
    llnp_pkg::t_status r_status, n_status;
    logic              r_equal, n_equal;
    llnp_pkg::t_ptr    r_free, n_free;

    logic              r_out_vld, n_out_vld;
    llnp_pkg::t_ptr    r_out_newh, n_out_newh;
    llnp_pkg::t_ptr    r_out_slot, n_out_slot;
    llnp_pkg::t_ptr    r_out_free, n_out_free;
    llnp_pkg::t_status r_out_status, n_out_status;
    logic              r_out_equal, n_out_equal;

    llnp_pkg::t_link_wr  link_wr;
    llnp_pkg::t_value_wr value_wr;
    llnp_pkg::t_rd_addr  rd_addr;
    llnp_pkg::t_ptr      link_a;
    llnp_pkg::t_ptr      link_b;
    llnp_pkg::t_value    value_a;
    llnp_pkg::t_value    value_b;

    llnp_pkg::t_step steps_inc;
    logic            steps_last;
    logic            walk_less;
    logic            cmp_eq;
    logic            out_load;

    llnp_link_store u_link (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (link_wr),
        .i_rd_addr (rd_addr),
        .o_rd_a    (link_a),
        .o_rd_b    (link_b)
    );

    llnp_value_store u_value (
        .i_clk     (i_clk),
        .i_wr      (value_wr),
        .i_rd_addr (rd_addr),
        .o_rd_a    (value_a),
        .o_rd_b    (value_b)
    );

    assign steps_inc  = r_steps + 1'b1;
    assign steps_last = (steps_inc == llnp_pkg::STEP_W'(llnp_pkg::NODE_COUNT));
    assign walk_less  = $signed(value_a) < $signed(r_val);
    assign cmp_eq     = (value_a == value_b);
    assign out_load   = (r_state == llnp_pkg::S_FINISH) && (!r_out_vld || i_out_ready);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            llnp_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = llnp_pkg::S_DISPATCH;
                end
            end
            llnp_pkg::S_DISPATCH: begin
                unique case (r_op) inside
                    llnp_pkg::OP_INS_FRONT, llnp_pkg::OP_INS_SORTED: begin
                        n_state = r_free.nil ? llnp_pkg::S_FINISH : llnp_pkg::S_ALLOC;
                    end
                    llnp_pkg::OP_DEL_FRONT: begin
                        n_state = r_head.nil ? llnp_pkg::S_FINISH : llnp_pkg::S_DELETE;
                    end
                    default: begin
                        n_state = (r_head.nil || r_other.nil) ? llnp_pkg::S_FINISH
                                                              : llnp_pkg::S_CMP;
                    end
                endcase
            end
            llnp_pkg::S_ALLOC: begin
                if (r_op == llnp_pkg::OP_INS_SORTED && !r_head.nil) begin
                    n_state = llnp_pkg::S_WALK;
                end else begin
                    n_state = llnp_pkg::S_LINK;
                end
            end
            llnp_pkg::S_WALK: begin
                if (!(walk_less && !link_a.nil && !steps_last)) begin
                    n_state = llnp_pkg::S_LINK;
                end
            end
            llnp_pkg::S_LINK: begin
                n_state = r_prev.nil ? llnp_pkg::S_FINISH : llnp_pkg::S_LINK_PREV;
            end
            llnp_pkg::S_LINK_PREV: begin
                n_state = llnp_pkg::S_FINISH;
            end
            llnp_pkg::S_DELETE: begin
                n_state = llnp_pkg::S_FINISH;
            end
            llnp_pkg::S_CMP: begin
                if (!(cmp_eq && !link_a.nil && !link_b.nil && !steps_last)) begin
                    n_state = llnp_pkg::S_FINISH;
                end
            end
            llnp_pkg::S_FINISH: begin
                if (!r_out_vld || i_out_ready) begin
                    n_state = llnp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = llnp_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_op     = r_op;
        n_head   = r_head;
        n_other  = r_other;
        n_val    = r_val;
        n_cur    = r_cur;
        n_oth    = r_oth;
        n_prev   = r_prev;
        n_steps  = r_steps;
        n_slot   = r_slot;
        n_newh   = r_newh;
        n_status = r_status;
        n_equal  = r_equal;
        n_free   = r_free;

        link_wr    = '0;
        value_wr   = '0;
        rd_addr.a  = r_cur.idx;
        rd_addr.b  = r_oth.idx;
        o_in_ready = 1'b0;

        unique case (r_state)
            llnp_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_op     = llnp_pkg::t_op'(i_operation);
                    n_head   = llnp_pkg::head_to_ptr(i_list_head);
                    n_other  = llnp_pkg::head_to_ptr(i_other_head);
                    n_val    = i_value[llnp_pkg::VALUE_BITS-1:0];
                    n_cur    = llnp_pkg::head_to_ptr(i_list_head);
                    n_oth    = llnp_pkg::head_to_ptr(i_other_head);
                    n_prev   = llnp_pkg::PTR_NIL;
                    n_steps  = '0;
                    n_slot   = llnp_pkg::PTR_NIL;
                    n_newh   = llnp_pkg::head_to_ptr(i_list_head);
                    n_status = llnp_pkg::ST_DONE;
                    n_equal  = 1'b0;
                end
            end
            llnp_pkg::S_DISPATCH: begin
                unique case (r_op) inside
                    llnp_pkg::OP_INS_FRONT, llnp_pkg::OP_INS_SORTED: begin
                        rd_addr.a = r_free.idx;
                        if (r_free.nil) begin
                            n_status = llnp_pkg::ST_FULL;
                        end
                    end
                    llnp_pkg::OP_DEL_FRONT: begin
                        rd_addr.a = r_head.idx;
                        if (r_head.nil) begin
                            n_status = llnp_pkg::ST_EMPTY;
                            n_newh   = llnp_pkg::PTR_NIL;
                        end
                    end
                    default: begin
                        rd_addr.a = r_head.idx;
                        rd_addr.b = r_other.idx;
                        n_equal   = r_head.nil && r_other.nil;
                    end
                endcase
            end
            llnp_pkg::S_ALLOC: begin
                n_slot    = r_free;
                n_free    = link_a;
                rd_addr.a = r_head.idx;
            end
            llnp_pkg::S_WALK: begin
                rd_addr.a = link_a.idx;
                if (walk_less) begin
                    n_prev  = r_cur;
                    n_cur   = link_a;
                    n_steps = steps_inc;
                end
            end
            llnp_pkg::S_LINK: begin
                value_wr = '{en: 1'b1, addr: r_slot.idx, data: r_val};
                link_wr  = '{en: 1'b1, addr: r_slot.idx, data: r_cur};
                if (r_prev.nil) begin
                    n_newh = r_slot;
                end
            end
            llnp_pkg::S_LINK_PREV: begin
                link_wr = '{en: 1'b1, addr: r_prev.idx, data: r_slot};
            end
            llnp_pkg::S_DELETE: begin
                n_newh  = link_a;
                link_wr = '{en: 1'b1, addr: r_head.idx, data: r_free};
                n_free  = r_head;
                n_slot  = r_head;
            end
            llnp_pkg::S_CMP: begin
                rd_addr.a = link_a.idx;
                rd_addr.b = link_b.idx;
                if (cmp_eq) begin
                    n_cur   = link_a;
                    n_oth   = link_b;
                    n_steps = steps_inc;
                    n_equal = link_a.nil && link_b.nil;
                end else begin
                    n_equal = 1'b0;
                end
            end
            llnp_pkg::S_FINISH: begin
            end
            default: begin
            end
        endcase
    end

    // output register
    always_comb begin
        n_out_vld    = r_out_vld && !i_out_ready;
        n_out_newh   = r_out_newh;
        n_out_slot   = r_out_slot;
        n_out_free   = r_out_free;
        n_out_status = r_out_status;
        n_out_equal  = r_out_equal;
        if (out_load) begin
            n_out_vld    = 1'b1;
            n_out_newh   = r_newh;
            n_out_slot   = r_slot;
            n_out_free   = r_free;
            n_out_status = r_status;
            n_out_equal  = r_equal;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= llnp_pkg::S_IDLE;
            r_out_vld <= 1'b0;
            r_free    <= '{nil: 1'b0, idx: llnp_pkg::IDX_W'(llnp_pkg::NODE_COUNT - 1)};
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_free    <= n_free;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_head       <= n_head;
        r_other      <= n_other;
        r_val        <= n_val;
        r_cur        <= n_cur;
        r_oth        <= n_oth;
        r_prev       <= n_prev;
        r_steps      <= n_steps;
        r_slot       <= n_slot;
        r_newh       <= n_newh;
        r_status     <= n_status;
        r_equal      <= n_equal;
        r_out_newh   <= n_out_newh;
        r_out_slot   <= n_out_slot;
        r_out_free   <= n_out_free;
        r_out_status <= n_out_status;
        r_out_equal  <= n_out_equal;
    end

    assign o_out_valid = r_out_vld;
    assign o_new_head  = llnp_pkg::ptr_to_head(r_out_newh);
    assign o_slot      = llnp_pkg::ptr_to_head(r_out_slot);
    assign o_free_head = llnp_pkg::ptr_to_head(r_out_free);
    assign o_status    = r_out_status;
    assign o_equal     = r_out_equal;

`ifndef SYNTHESIS
    // walks never write the memories
    a_no_write_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == llnp_pkg::S_WALK || r_state == llnp_pkg::S_CMP)
            |-> (!link_wr.en && !value_wr.en))
        else $error("memory write during list walk");

    // free head moves only on allocation or release
    a_free_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != llnp_pkg::S_ALLOC && r_state != llnp_pkg::S_DELETE)
            |=> $stable(r_free))
        else $error("free head changed outside alloc or delete");

    // dropped insert reports no slot
    a_full_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == llnp_pkg::ST_FULL) |-> (o_slot == '1))
        else $error("pool full result carries a slot");
`endif

endmodule
